/* rtl/core/pftd_pkg.sv */
`default_nettype none

package pftd_pkg;

    // Fixed widths of the stream fields.
    localparam int VALUE_W = 32;
    localparam int PRIME_W = 31;
    localparam int COUNT_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/prime_filter_trial_division_top.sv */
// A rejected value is dropped in the cycle it is accepted; 2 goes through ST_EMIT to the output register.
// An odd value is tried against odd divisors from 3 upward, with W = min(VALUE_BITS - 1, 32); each trial
// is a W-bit bit-serial division in ST_DIV and one check in ST_CHECK. A prime then passes through
// ST_EMIT into the output register. A full output register stalls the result.
// One value is tested at a time; a 31-bit prime needs about 23170 trials.
// Reset (aresetn low, synchronous) empties the output register, idles the sequencer, zeroes the count.
`default_nettype none

module prime_filter_trial_division_top #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire logic [pftd_pkg::VALUE_W-1:0]  s_value,
    output      logic                          m_valid,
    input  wire logic                          m_ready,
    output      logic [pftd_pkg::PRIME_W-1:0]  m_prime_value,
    output      logic [pftd_pkg::COUNT_W-1:0]  m_primes_so_far
);
    import pftd_pkg::*;

    // The value is read as a VALUE_BITS-wide two's complement number taken from the low bits of
    // the field. Above 32 bits the field's upper bits are zero, so the value is never negative
    // and its magnitude is the whole 32-bit field.
    localparam int XW       = (VALUE_BITS > 32) ? 32 : VALUE_BITS - 1;
    localparam int SIGN_POS = (VALUE_BITS > 32) ? 31 : VALUE_BITS - 1;
    // A divisor never exceeds the square root of the magnitude plus two.
    localparam int DW       = (XW + 1) / 2 + 1;
    localparam int CW       = $clog2(XW);

    state_t            state_reg, state_next;
    logic [XW-1:0]     value_reg, value_next;     // magnitude under test
    logic [XW-1:0]     acc_reg, acc_next;         // dividend bits out, quotient bits in
    logic [DW-1:0]     rem_reg, rem_next;         // partial remainder, always below divisor
    logic [DW-1:0]     divisor_reg, divisor_next; // current odd trial divisor
    logic [CW-1:0]     bit_cnt_reg, bit_cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [PRIME_W-1:0] prime_reg, prime_next;
    logic [COUNT_W-1:0] prime_total_reg, prime_total_next;

    logic              in_sign;
    logic [XW-1:0]     in_mag;
    logic              in_accept;
    logic              out_load;
    logic [DW:0]       shifted;
    logic              sub_ok;
    logic [63:0]       value_ext;

    assign in_sign   = (VALUE_BITS > 32) ? 1'b0 : s_value[SIGN_POS];
    assign in_mag    = s_value[XW-1:0];
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;

    // The output register may take a new result when it is empty or its beat leaves now.
    assign out_load  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    // One restoring-division step: bring down the next dividend bit and subtract if it fits.
    assign shifted   = {rem_reg, acc_reg[XW-1]};
    assign sub_ok    = (shifted >= {1'b0, divisor_reg});
    assign value_ext = 64'(value_reg);

    always_comb begin
        state_next       = state_reg;
        value_next       = value_reg;
        acc_next         = acc_reg;
        rem_next         = rem_reg;
        divisor_next     = divisor_reg;
        bit_cnt_next     = bit_cnt_reg;
        prime_next       = prime_reg;
        prime_total_next = prime_total_reg;
        m_valid_next     = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    value_next = in_mag;
                    if (in_sign || (in_mag <= XW'(1))) begin
                        // Negative, zero or one: not prime, the beat is dropped.
                        state_next = ST_IDLE;
                    end else if (in_mag == XW'(2)) begin
                        state_next = ST_EMIT;
                    end else if (!in_mag[0]) begin
                        // Even values above two are composite.
                        state_next = ST_IDLE;
                    end else begin
                        acc_next     = in_mag;
                        rem_next     = '0;
                        divisor_next = DW'(3);
                        bit_cnt_next = '0;
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next     = sub_ok ? DW'(shifted - {1'b0, divisor_reg}) : shifted[DW-1:0];
                acc_next     = {acc_reg[XW-2:0], sub_ok};
                bit_cnt_next = bit_cnt_reg + CW'(1);
                if (bit_cnt_reg == CW'(XW - 1)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // acc_reg now holds the quotient. Once the divisor exceeds it, the divisor's
                // square exceeds the value and no factor remains to be found.
                if (XW'(divisor_reg) > acc_reg) begin
                    state_next = ST_EMIT;
                end else if (rem_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    divisor_next = divisor_reg + DW'(2);
                    acc_next     = value_reg;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    prime_next   = value_ext[PRIME_W-1:0];
                    m_valid_next = 1'b1;
                    if (prime_total_reg != COUNT_MAX) begin
                        prime_total_next = prime_total_reg + COUNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            prime_total_reg <= '0;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            prime_total_reg <= prime_total_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge aclk) begin
        value_reg   <= value_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        bit_cnt_reg <= bit_cnt_next;
        prime_reg   <= prime_next;
    end

    // The count changes only when a result is loaded, so it is the count for the held beat.
    assign m_valid         = m_valid_reg;
    assign m_prime_value   = prime_reg;
    assign m_primes_so_far = prime_total_reg;

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < divisor_reg))
        else $error("partial remainder not below divisor");

    a_divisor_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (divisor_reg[0] && (divisor_reg >= DW'(3))))
        else $error("trial divisor is even or below three");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> ((prime_total_reg == $past(prime_total_reg) + COUNT_W'(1))
                      || (prime_total_reg == COUNT_MAX)))
        else $error("prime count did not advance on a new result");

    a_result_at_least_two: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (prime_reg[PRIME_W-1:1] != '0))
        else $error("result value below two");

    a_no_input_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV || state_reg == ST_CHECK) |=> !$past(in_accept))
        else $error("input accepted while a test was running");

endmodule

`default_nettype wire
